FILE: src/btn_gest_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the button gesture detector.
// No dependencies; imported by btn_gest_update and button_gesture_detector_unit.
package btn_gest_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int BTN_AW      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int TIME_W      = 32;
  localparam int COUNT_W     = 32;
  localparam int CFG_TIME_W  = 31;
  localparam int MASK_W      = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_TIME_W-1:0] DEBOUNCE_RST = CFG_TIME_W'(40 * 1000);
  localparam logic [CFG_TIME_W-1:0] DOUBLE_RST   = CFG_TIME_W'(350 * 1000);
  localparam logic [CFG_TIME_W-1:0] LONG_RST     = CFG_TIME_W'(2000 * 1000);
  localparam logic [MASK_W-1:0]     MASK_RST     = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_DOUBLE   = 2'd1,
    CFG_LONG     = 2'd2,
    CFG_MASK     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_SHORT  = 2'd1,
    GEST_DOUBLE = 2'd2,
    GEST_LONG   = 2'd3
  } gesture_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] debounce_us;
    logic [CFG_TIME_W-1:0] double_window_us;
    logic [CFG_TIME_W-1:0] long_press_us;
    logic [MASK_W-1:0]     active_level_mask;
  } cfg_t;

  // Per-button record held in the state memory.
  typedef struct packed {
    logic               started;
    logic               raw;
    logic               stable;
    logic               long_done;
    logic               short_waiting;
    logic               double_armed;
    logic [TIME_W-1:0]  raw_change_time;
    logic [TIME_W-1:0]  press_time;
    logic [TIME_W-1:0]  release_time;
    logic [COUNT_W-1:0] short_total;
    logic [COUNT_W-1:0] double_total;
    logic [COUNT_W-1:0] long_total;
  } btn_state_t;

  localparam int STATE_W = $bits(btn_state_t);

  typedef struct packed {
    gesture_t           gesture;
    logic               pressed_now;
    logic [COUNT_W-1:0] count;
  } upd_result_t;

endpackage

FILE: src/btn_gest_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module btn_gest_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/btn_gest_update.sv
`timescale 1ns / 1ps
// Per-sample state update: debounce, short / double / long press detection.
// Depends on btn_gest_pkg.
module btn_gest_update
  import btn_gest_pkg::*;
(
  input  cfg_t              cfg,
  input  logic [BTN_AW-1:0] button,
  input  logic              pin_level,
  input  logic [TIME_W-1:0] now,
  input  btn_state_t        st_in,
  output btn_state_t        st_out,
  output upd_result_t       res
);

  logic                  pressed;
  logic [TIME_W-1:0]     since_release;
  logic [TIME_W-1:0]     since_raw;
  logic [TIME_W-1:0]     since_press;
  logic [CFG_TIME_W-1:0] long_th;
  btn_state_t            s;

  always_comb begin
    pressed = (pin_level == cfg.active_level_mask[button]);
    long_th = (cfg.long_press_us == '0) ? CFG_TIME_W'(1) : cfg.long_press_us;
    since_release = now - st_in.release_time;
    s = st_in;
    res.gesture = GEST_NONE;
    res.count = '0;
    since_raw = '0;
    since_press = '0;

    if (!st_in.started) begin
      // capture only
      s.started = 1'b1;
      s.raw = pressed;
      s.stable = pressed;
      s.raw_change_time = now;
      s.press_time = pressed ? now : '0;
    end else begin
      if (s.short_waiting && !s.stable &&
          since_release > {1'b0, cfg.double_window_us}) begin
        s.short_waiting = 1'b0;
        s.short_total = s.short_total + 1'b1;
        res.gesture = GEST_SHORT;
        res.count = s.short_total;
      end

      if (pressed != s.raw) begin
        s.raw = pressed;
        s.raw_change_time = now;
      end

      since_raw = now - s.raw_change_time;
      if (s.raw != s.stable && since_raw >= {1'b0, cfg.debounce_us}) begin
        s.stable = s.raw;
        if (s.stable) begin
          s.press_time = now;
          s.long_done = 1'b0;
          s.double_armed = s.short_waiting &&
                           (since_release <= {1'b0, cfg.double_window_us});
        end else if (!s.long_done) begin
          if (s.double_armed) begin
            s.short_waiting = 1'b0;
            s.double_armed = 1'b0;
            s.double_total = s.double_total + 1'b1;
            res.gesture = GEST_DOUBLE;
            res.count = s.double_total;
          end else begin
            s.short_waiting = 1'b1;
            s.release_time = now;
          end
        end
      end

      since_press = now - s.press_time;
      if (s.stable && !s.long_done && since_press >= {1'b0, long_th}) begin
        s.long_done = 1'b1;
        s.short_waiting = 1'b0;
        s.double_armed = 1'b0;
        s.long_total = s.long_total + 1'b1;
        res.gesture = GEST_LONG;
        res.count = s.long_total;
      end
    end

    res.pressed_now = s.stable;
    st_out = s;
  end

endmodule

FILE: src/button_gesture_detector_unit.sv
`timescale 1ns / 1ps
// Top level of the button gesture detector: config registers, state memory
// pipeline with write-back forwarding. Depends on btn_gest_pkg, btn_gest_ram,
// btn_gest_update.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  in_     | input     | in_valid/in_stall  | button_index, pin_level, time_us
//  out_    | output    | out_valid/out_stall| out_button, gesture, pressed_now, count
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One sample per cycle sustained while the output is not stalled; the memory read is
// taken when a sample is accepted into the s1 stage, and update plus write-back into
// the output register happen when that stage advances, which raises out_valid.
// A sample for the button just written takes the write-back data, not the memory.
// Reset clears the per-button valid bits, so every record reads as zero until
// first written; config returns to its defaults. cfg_ready is always high.
// A stalled output holds the update stage; in_stall rises only when that stage
// is occupied and cannot advance.
module button_gesture_detector_unit
  import btn_gest_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BTN_AW-1:0]     in_button_index,
  input  logic                  in_pin_level,
  input  logic [TIME_W-1:0]     in_time_us,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BTN_AW-1:0]     out_button,
  output logic [1:0]            out_gesture,
  output logic                  out_pressed_now,
  output logic [COUNT_W-1:0]    out_gesture_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_TIME_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BTN_AW-1:0] s1_btn_r;
  logic              s1_pin_r;
  logic [TIME_W-1:0] s1_time_r;

  logic                   wb_valid_r, wb_valid_nxt;
  logic [BTN_AW-1:0]      wb_addr_r;
  btn_state_t             wb_data_r;
  logic [NUM_BUTTONS-1:0] ent_valid_r, ent_valid_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [BTN_AW-1:0]  out_button_r;
  gesture_t           out_gesture_r;
  logic               out_pressed_r;
  logic [COUNT_W-1:0] out_count_r;

  logic               accept;
  logic               s1_adv;
  logic               wr_en;
  logic [STATE_W-1:0] ram_rdata;
  btn_state_t         cur_state;
  btn_state_t         new_state;
  upd_result_t        upd_res;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !s1_adv;
  assign accept    = in_valid && !in_stall;
  assign wr_en     = s1_valid_r && s1_adv;

  // config register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: cfg_nxt.debounce_us = cfg_data;
        CFG_DOUBLE:   cfg_nxt.double_window_us = cfg_data;
        CFG_LONG:     cfg_nxt.long_press_us = cfg_data;
        CFG_MASK:     cfg_nxt.active_level_mask = cfg_data[MASK_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  btn_gest_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_btn_r),
    .wdata (new_state),
    .re    (accept),
    .raddr (in_button_index),
    .rdata (ram_rdata)
  );

  // forward the most recent write-back; never-written records read as zero
  always_comb begin
    if (wb_valid_r && (wb_addr_r == s1_btn_r)) begin
      cur_state = wb_data_r;
    end else if (ent_valid_r[s1_btn_r]) begin
      cur_state = btn_state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  btn_gest_update u_update (
    .cfg       (cfg_r),
    .button    (s1_btn_r),
    .pin_level (s1_pin_r),
    .now       (s1_time_r),
    .st_in     (cur_state),
    .st_out    (new_state),
    .res       (upd_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    wb_valid_nxt  = wb_valid_r;
    ent_valid_nxt = ent_valid_r;
    if (wr_en) begin
      wb_valid_nxt = 1'b1;
      ent_valid_nxt[s1_btn_r] = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (wr_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{DEBOUNCE_RST, DOUBLE_RST, LONG_RST, MASK_RST};
      s1_valid_r  <= 1'b0;
      wb_valid_r  <= 1'b0;
      ent_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      s1_valid_r  <= s1_valid_nxt;
      wb_valid_r  <= wb_valid_nxt;
      ent_valid_r <= ent_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_btn_r  <= in_button_index;
      s1_pin_r  <= in_pin_level;
      s1_time_r <= in_time_us;
    end
    if (wr_en) begin
      wb_addr_r     <= s1_btn_r;
      wb_data_r     <= new_state;
      out_button_r  <= s1_btn_r;
      out_gesture_r <= upd_res.gesture;
      out_pressed_r <= upd_res.pressed_now;
      out_count_r   <= upd_res.count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_button        = out_button_r;
  assign out_gesture       = out_gesture_r;
  assign out_pressed_now   = out_pressed_r;
  assign out_gesture_count = out_count_r;

endmodule
